>>> rtl/core/hex_uid_allowlist_matcher_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hex UID allowlist matcher.
// The assertions compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HEX_UID_ALLOWLIST_MATCHER_DEFINES_SVH
`define HEX_UID_ALLOWLIST_MATCHER_DEFINES_SVH

`ifndef SYNTHESIS

`define HUAM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("huam assertion failed");

`define HUAM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("huam assertion failed");

`else

`define HUAM_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define HUAM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/core/huam_pkg.sv
// ----------------------------------------------------------------------------
// huam_pkg
// Sizes, field widths and operation codes of the hex UID allowlist matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package huam_pkg;

   localparam int MAX_ENTRIES       = 8;
   localparam int UID_TEXT_CAPACITY = 21;
   localparam int DIGITS_PER_ENTRY  = UID_TEXT_CAPACITY - 1;

   localparam int OPERATION_W   = 3;
   localparam int CHARACTER_W   = 8;
   localparam int ENTRY_COUNT_W = 4;
   localparam int DIGIT_W       = 4;

   localparam int ENTRY_IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int COUNT_W      = $clog2(MAX_ENTRIES + 1);
   localparam int LEN_W        = $clog2(DIGITS_PER_ENTRY + 1);
   localparam int DIGIT_ADDR_W = $clog2(DIGITS_PER_ENTRY);

   typedef enum logic [OPERATION_W-1:0] {
      OP_CLEAR      = 3'd0,
      OP_LIST_CHAR  = 3'd1,
      OP_LIST_END   = 3'd2,
      OP_QUERY_CHAR = 3'd3,
      OP_QUERY_END  = 3'd4
   } op_type;

   localparam logic KIND_LIST  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

endpackage

`default_nettype wire

>>> rtl/core/huam_if.sv
// ----------------------------------------------------------------------------
// huam_if
// Request and response channel interfaces with a valid and ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface huam_req_if
   import huam_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [OPERATION_W-1:0] operation;
   logic [CHARACTER_W-1:0] character;

   modport source (output valid, output operation, output character, input ready);
   modport sink   (input valid, input operation, input character, output ready);
endinterface

interface huam_rsp_if
   import huam_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic                     result_kind;
   logic [ENTRY_COUNT_W-1:0] entry_count;
   logic                     allowed;

   modport source (output valid, output result_kind, output entry_count, output allowed,
                   input ready);
   modport sink   (input valid, input result_kind, input entry_count, input allowed,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/core/huam_ram.sv
// ----------------------------------------------------------------------------
// huam_ram
// Simple dual-port RAM with a registered read that returns write data when
// the read and write addresses collide.
// ----------------------------------------------------------------------------
`default_nettype none

module huam_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 20
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/hex_uid_allowlist_matcher.sv
// ----------------------------------------------------------------------------
// hex_uid_allowlist_matcher
// Loads an allowlist of hex UIDs from list text and answers queries against
// it, one character per item.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  req_chan | in        | operation, character
//  rsp_chan | out       | result_kind, entry_count, allowed
//
// One item is accepted per cycle while the response register is free or is
// being drained in the same cycle; a response appears in the cycle after its item.
// The per-entry digit RAMs are read every cycle at the next query position, so
// a query character compares all entries in the cycle it is accepted.
// Reset is synchronous and clears the entry count, token and query state.
// A response that waits on the receiver holds off every request item until it
// is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hex_uid_allowlist_matcher_defines.svh"

module hex_uid_allowlist_matcher
   import huam_pkg::*;
(
   input wire logic  clock,
   input wire logic  reset,
   huam_req_if.sink   req_chan,
   huam_rsp_if.source rsp_chan
);

   function automatic logic is_separator(input logic [CHARACTER_W-1:0] ch);
      return (ch == 8'h2C) || (ch == 8'h3B) || (ch == 8'h20) ||
             (ch == 8'h09) || (ch == 8'h0D) || (ch == 8'h0A);
   endfunction

   function automatic logic is_hex(input logic [CHARACTER_W-1:0] ch);
      return ((ch >= 8'h30) && (ch <= 8'h39)) || ((ch >= 8'h41) && (ch <= 8'h46)) ||
             ((ch >= 8'h61) && (ch <= 8'h66));
   endfunction

   function automatic logic [DIGIT_W-1:0] hex_digit(input logic [CHARACTER_W-1:0] ch);
      logic [CHARACTER_W-1:0] value;
      if (ch <= 8'h39) begin
         value = ch - 8'h30;
      end else if (ch <= 8'h46) begin
         value = ch - 8'h37;
      end else begin
         value = ch - 8'h57;
      end
      return value[DIGIT_W-1:0];
   endfunction

   logic [COUNT_W-1:0]     stored_entries_ff, stored_entries_in;
   logic [LEN_W-1:0]       token_length_ff, token_length_in;
   logic                   token_malformed_ff, token_malformed_in;
   logic [LEN_W-1:0]       query_length_ff, query_length_in;
   logic                   query_malformed_ff, query_malformed_in;
   logic [MAX_ENTRIES-1:0] entry_still_matching_ff, entry_still_matching_in;
   logic [LEN_W-1:0]       entry_digit_length_ff [MAX_ENTRIES];

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_kind_ff, rsp_kind_in;
   logic [ENTRY_COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                     rsp_allowed_ff, rsp_allowed_in;

   logic                   req_accept;
   logic                   emit;
   logic                   length_we;
   logic [MAX_ENTRIES-1:0] digit_we;
   logic [DIGIT_W-1:0]     char_digit;
   logic                   char_is_hex;
   logic                   char_is_sep;
   logic [ENTRY_IDX_W-1:0] write_entry;
   logic [MAX_ENTRIES-1:0] entry_active;
   logic [DIGIT_W-1:0]     rd_digit [MAX_ENTRIES];
   logic                   verdict;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign char_is_hex    = is_hex(req_chan.character);
   assign char_is_sep    = is_separator(req_chan.character);
   assign char_digit     = hex_digit(req_chan.character);
   assign write_entry    = stored_entries_ff[ENTRY_IDX_W-1:0];

   for (genvar e = 0; e < MAX_ENTRIES; e++) begin : g_entry
      assign entry_active[e] = COUNT_W'(e) < stored_entries_ff;

      huam_ram #(
         .WIDTH(DIGIT_W),
         .DEPTH(DIGITS_PER_ENTRY)
      ) u_digits (
         .clock  (clock),
         .wr_en  (digit_we[e]),
         .wr_addr(token_length_ff[DIGIT_ADDR_W-1:0]),
         .wr_data(char_digit),
         .rd_addr(query_length_in[DIGIT_ADDR_W-1:0]),
         .rd_data(rd_digit[e])
      );
   end

   always_comb begin
      verdict = 1'b0;
      for (int e = 0; e < MAX_ENTRIES; e++) begin
         if (entry_active[e] && entry_still_matching_ff[e] &&
             (entry_digit_length_ff[e] == query_length_ff)) begin
            verdict = 1'b1;
         end
      end
      verdict = verdict && !query_malformed_ff && (query_length_ff != '0);
   end

   always_comb begin
      stored_entries_in       = stored_entries_ff;
      token_length_in         = token_length_ff;
      token_malformed_in      = token_malformed_ff;
      query_length_in         = query_length_ff;
      query_malformed_in      = query_malformed_ff;
      entry_still_matching_in = entry_still_matching_ff;
      digit_we                = '0;
      length_we               = 1'b0;
      emit                    = 1'b0;
      rsp_kind_in             = KIND_LIST;
      rsp_allowed_in          = 1'b0;

      if (req_accept) begin
         case (op_type'(req_chan.operation))
            OP_CLEAR: begin
               query_length_in         = '0;
               query_malformed_in      = 1'b0;
               entry_still_matching_in = '1;
               stored_entries_in       = '0;
               token_length_in         = '0;
               token_malformed_in      = 1'b0;
            end
            OP_LIST_CHAR: begin
               query_length_in         = '0;
               query_malformed_in      = 1'b0;
               entry_still_matching_in = '1;
               if (stored_entries_ff < COUNT_W'(MAX_ENTRIES)) begin
                  if (char_is_sep) begin
                     if ((token_length_ff != '0) && !token_malformed_ff &&
                         !token_length_ff[0]) begin
                        length_we         = 1'b1;
                        stored_entries_in = stored_entries_ff + 1'b1;
                     end
                     token_length_in    = '0;
                     token_malformed_in = 1'b0;
                  end else if (!char_is_hex ||
                               (token_length_ff >= LEN_W'(DIGITS_PER_ENTRY))) begin
                     token_malformed_in = 1'b1;
                  end else begin
                     digit_we[write_entry] = 1'b1;
                     token_length_in       = token_length_ff + 1'b1;
                  end
               end
            end
            OP_LIST_END: begin
               query_length_in         = '0;
               query_malformed_in      = 1'b0;
               entry_still_matching_in = '1;
               if ((stored_entries_ff < COUNT_W'(MAX_ENTRIES)) &&
                   (token_length_ff != '0) && !token_malformed_ff &&
                   !token_length_ff[0]) begin
                  length_we         = 1'b1;
                  stored_entries_in = stored_entries_ff + 1'b1;
               end
               token_length_in    = '0;
               token_malformed_in = 1'b0;
               emit               = 1'b1;
               rsp_kind_in        = KIND_LIST;
            end
            OP_QUERY_CHAR: begin
               if (!char_is_hex || (query_length_ff >= LEN_W'(DIGITS_PER_ENTRY))) begin
                  query_malformed_in = 1'b1;
               end else begin
                  for (int e = 0; e < MAX_ENTRIES; e++) begin
                     if (entry_active[e] &&
                         ((query_length_ff >= entry_digit_length_ff[e]) ||
                          (rd_digit[e] != char_digit))) begin
                        entry_still_matching_in[e] = 1'b0;
                     end
                  end
                  query_length_in = query_length_ff + 1'b1;
               end
            end
            OP_QUERY_END: begin
               emit                    = 1'b1;
               rsp_kind_in             = KIND_QUERY;
               rsp_allowed_in          = verdict;
               query_length_in         = '0;
               query_malformed_in      = 1'b0;
               entry_still_matching_in = '1;
            end
            default: begin
            end
         endcase
      end

      rsp_count_in = ENTRY_COUNT_W'(stored_entries_in);
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_entries_ff       <= '0;
         token_length_ff         <= '0;
         token_malformed_ff      <= 1'b0;
         query_length_ff         <= '0;
         query_malformed_ff      <= 1'b0;
         entry_still_matching_ff <= '1;
         rsp_valid_ff            <= 1'b0;
      end else begin
         stored_entries_ff       <= stored_entries_in;
         token_length_ff         <= token_length_in;
         token_malformed_ff      <= token_malformed_in;
         query_length_ff         <= query_length_in;
         query_malformed_ff      <= query_malformed_in;
         entry_still_matching_ff <= entry_still_matching_in;
         rsp_valid_ff            <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (length_we) begin
         entry_digit_length_ff[write_entry] <= token_length_ff;
      end
      if (emit) begin
         rsp_kind_ff    <= rsp_kind_in;
         rsp_count_ff   <= rsp_count_in;
         rsp_allowed_ff <= rsp_allowed_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.result_kind = rsp_kind_ff;
   assign rsp_chan.entry_count = rsp_count_ff;
   assign rsp_chan.allowed     = rsp_allowed_ff;

   `HUAM_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1,
                      stored_entries_ff <= COUNT_W'(MAX_ENTRIES))
   `HUAM_ASSERT_IMPLY(a_query_bound, clock, reset, 1'b1,
                      query_length_ff <= LEN_W'(DIGITS_PER_ENTRY))
   `HUAM_ASSERT_IMPLY(a_list_never_allowed, clock, reset,
                      rsp_valid_ff && (rsp_kind_ff == KIND_LIST), !rsp_allowed_ff)
   `HUAM_ASSERT_NEXT(a_count_holds_idle, clock, reset, !req_accept,
                     $stable(stored_entries_ff))

endmodule

`default_nettype wire

>>> bench/hex_uid_allowlist_matcher_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hex_uid_allowlist_matcher_checker
// Watches the request and response channels of the allowlist matcher. It keeps
// its own copy of the allowlist and query state, works out the answer that
// each accepted item calls for, and compares every accepted answer, field by
// field, with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module hex_uid_allowlist_matcher_checker
   import huam_pkg::*;
(
   input  logic clock,
   input  logic reset,
   huam_req_if  req_mon,
   huam_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_answers
);

   localparam logic [CHARACTER_W-1:0] CH_COMMA = ",";
   localparam logic [CHARACTER_W-1:0] CH_SEMI  = ";";
   localparam logic [CHARACTER_W-1:0] CH_SPACE = " ";
   localparam logic [CHARACTER_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHARACTER_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHARACTER_W-1:0] CH_CR    = 8'h0D;
   localparam logic [4:0]             NOT_HEX  = 5'd16;

   typedef struct packed {
      logic                     result_kind;
      logic [ENTRY_COUNT_W-1:0] entry_count;
      logic                     allowed;
   } answer_type;

   answer_type expected_answers[$];

   logic [DIGIT_W-1:0]     digit_mem [MAX_ENTRIES*DIGITS_PER_ENTRY];
   int                     entry_len [MAX_ENTRIES];
   int                     entry_total;
   int                     token_len;
   logic                   token_bad;
   int                     query_len;
   logic                   query_bad;
   logic [MAX_ENTRIES-1:0] match_mask;

   function automatic logic is_separator(input logic [CHARACTER_W-1:0] ch);
      return ch == CH_COMMA || ch == CH_SEMI || ch == CH_SPACE ||
             ch == CH_TAB || ch == CH_CR || ch == CH_LF;
   endfunction

   function automatic logic [4:0] hex_value(input logic [CHARACTER_W-1:0] ch);
      if (ch >= "0" && ch <= "9") begin
         return 5'(ch - "0");
      end else if (ch >= "A" && ch <= "F") begin
         return 5'(ch - "A" + 8'd10);
      end else if (ch >= "a" && ch <= "f") begin
         return 5'(ch - "a" + 8'd10);
      end
      return NOT_HEX;
   endfunction

   task automatic restart_query();
      query_len  = 0;
      query_bad  = 1'b0;
      match_mask = '1;
   endtask

   task automatic close_token();
      if (entry_total < MAX_ENTRIES && token_len != 0 && !token_bad &&
          token_len % 2 == 0 && token_len <= DIGITS_PER_ENTRY) begin
         entry_len[entry_total] = token_len;
         entry_total++;
      end
      token_len = 0;
      token_bad = 1'b0;
   endtask

   task automatic take_list_char(input logic [CHARACTER_W-1:0] ch);
      logic [4:0] v;
      if (entry_total >= MAX_ENTRIES) begin
         return;
      end
      if (is_separator(ch)) begin
         close_token();
         return;
      end
      v = hex_value(ch);
      if (v == NOT_HEX || token_len >= DIGITS_PER_ENTRY) begin
         token_bad = 1'b1;
      end else begin
         digit_mem[entry_total*DIGITS_PER_ENTRY + token_len] = v[DIGIT_W-1:0];
         token_len++;
      end
   endtask

   task automatic take_query_char(input logic [CHARACTER_W-1:0] ch);
      logic [4:0] v;
      v = hex_value(ch);
      if (v == NOT_HEX || query_len >= DIGITS_PER_ENTRY) begin
         query_bad = 1'b1;
         return;
      end
      for (int e = 0; e < entry_total; e++) begin
         if (query_len >= entry_len[e] ||
             digit_mem[e*DIGITS_PER_ENTRY + query_len] != v[DIGIT_W-1:0]) begin
            match_mask[e] = 1'b0;
         end
      end
      query_len++;
   endtask

   function automatic logic query_allowed();
      if (query_bad || query_len == 0) begin
         return 1'b0;
      end
      for (int e = 0; e < entry_total; e++) begin
         if (match_mask[e] && entry_len[e] == query_len) begin
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   task automatic clear_allowlist_state();
      for (int i = 0; i < MAX_ENTRIES*DIGITS_PER_ENTRY; i++) begin
         digit_mem[i] = '0;
      end
      for (int e = 0; e < MAX_ENTRIES; e++) begin
         entry_len[e] = 0;
      end
      entry_total = 0;
      token_len   = 0;
      token_bad   = 1'b0;
      restart_query();
   endtask

   task automatic predict_answer(input logic [OPERATION_W-1:0] op,
                                 input logic [CHARACTER_W-1:0] ch);
      answer_type ans;
      case (op)
         OP_CLEAR: begin
            restart_query();
            entry_total = 0;
            token_len   = 0;
            token_bad   = 1'b0;
         end
         OP_LIST_CHAR: begin
            restart_query();
            take_list_char(ch);
         end
         OP_LIST_END: begin
            restart_query();
            if (entry_total < MAX_ENTRIES) begin
               close_token();
            end
            token_len = 0;
            token_bad = 1'b0;
            ans.result_kind = KIND_LIST;
            ans.entry_count = ENTRY_COUNT_W'(entry_total);
            ans.allowed     = 1'b0;
            expected_answers.push_back(ans);
         end
         OP_QUERY_CHAR: begin
            take_query_char(ch);
         end
         OP_QUERY_END: begin
            ans.result_kind = KIND_QUERY;
            ans.entry_count = ENTRY_COUNT_W'(entry_total);
            ans.allowed     = query_allowed();
            expected_answers.push_back(ans);
            restart_query();
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      answer_type seen;
      answer_type want;
      if (reset) begin
         clear_allowlist_state();
         expected_answers.delete();
      end else begin
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            predict_answer(req_mon.operation, req_mon.character);
         end
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            seen.result_kind = rsp_mon.result_kind;
            seen.entry_count = rsp_mon.entry_count;
            seen.allowed     = rsp_mon.allowed;
            if (expected_answers.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected answer kind %0d count %0d allowed %0d, none expected",
                        $time, seen.result_kind, seen.entry_count, seen.allowed);
            end else begin
               want = expected_answers.pop_front();
               if (seen.result_kind !== want.result_kind ||
                   seen.entry_count !== want.entry_count ||
                   seen.allowed !== want.allowed) begin
                  fail_count++;
                  $display("%0t: answer mismatch, expected kind %0d count %0d allowed %0d, %s",
                           $time, want.result_kind, want.entry_count, want.allowed,
                           $sformatf("got kind %0d count %0d allowed %0d",
                                     seen.result_kind, seen.entry_count, seen.allowed));
               end
            end
         end
      end
      pending_answers = expected_answers.size();
   end

endmodule

>>> bench/hex_uid_allowlist_matcher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hex_uid_allowlist_matcher_tb
// Drives list text, queries and stray operations into the allowlist matcher
// under several idle and stall patterns, including a long response hold-off,
// and reports the verdict from the failure count and pending answers of the checker.
// ----------------------------------------------------------------------------
module hex_uid_allowlist_matcher_tb;
   import huam_pkg::*;

   localparam int ITEM_TARGET     = 700;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int SETTLE_CYCLES   = 20;
   localparam int POOL_SIZE       = 16;

   localparam logic [OPERATION_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OPERATION_W-1:0] OP_SPARE_LAST  = 3'd7;

   localparam logic [CHARACTER_W-1:0] CH_COMMA = ",";
   localparam logic [CHARACTER_W-1:0] CH_SEMI  = ";";
   localparam logic [CHARACTER_W-1:0] CH_SPACE = " ";
   localparam logic [CHARACTER_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHARACTER_W-1:0] CH_LF    = 8'h0A;
   localparam logic [CHARACTER_W-1:0] CH_CR    = 8'h0D;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_answers;
   int   send_idle_pct;
   int   rsp_stall_pct;
   int   hold_off_asked;
   int   hold_off_done;
   int   cycle_count;
   int   items_sent;

   logic [DIGIT_W-1:0] pool_digit [POOL_SIZE][DIGITS_PER_ENTRY];
   int                 pool_len [POOL_SIZE];
   int                 pool_fill;
   int                 pool_next;

   huam_req_if req_chan();
   huam_rsp_if rsp_chan();

   hex_uid_allowlist_matcher i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   hex_uid_allowlist_matcher_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .fail_count      (fail_count),
      .pending_answers (pending_answers)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   // A long hold-off is started whenever the stimulus asks for one.
   initial begin
      int left;
      left           = 0;
      hold_off_done  = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (left == 0 && hold_off_done != hold_off_asked) begin
            left = HOLD_OFF_CYCLES;
            hold_off_done++;
         end
         if (left > 0) begin
            rsp_chan.ready <= 1'b0;
            left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   task automatic send_item(input logic [OPERATION_W-1:0] op,
                            input logic [CHARACTER_W-1:0] ch);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.operation <= op;
      req_chan.character <= ch;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) begin
         @(posedge clock);
      end
      @(negedge clock);
      if (op <= OP_QUERY_END) begin
         items_sent++;
      end
   endtask

   function automatic logic [CHARACTER_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      if (d < 10) begin
         return CHARACTER_W'("0" + d);
      end else if ($urandom_range(0, 1) == 1) begin
         return CHARACTER_W'("a" + d - 10);
      end
      return CHARACTER_W'("A" + d - 10);
   endfunction

   function automatic logic [CHARACTER_W-1:0] bad_char();
      case ($urandom_range(0, 5))
         0:       return 8'h00;
         1:       return {1'b1, 7'($urandom)};
         2:       return CHARACTER_W'("g" + $urandom_range(0, 19));
         3:       return CHARACTER_W'("G" + $urandom_range(0, 19));
         4:       return ":";
         default: return "-";
      endcase
   endfunction

   function automatic logic [CHARACTER_W-1:0] sep_char();
      case ($urandom_range(0, 5))
         0:       return CH_COMMA;
         1:       return CH_SEMI;
         2:       return CH_SPACE;
         3:       return CH_TAB;
         4:       return CH_CR;
         default: return CH_LF;
      endcase
   endfunction

   task automatic send_token(input bit with_sep);
      logic [DIGIT_W-1:0] digs [32];
      int len;
      int r;
      int bad_at;
      bad_at = -1;
      r      = $urandom_range(0, 99);
      if (r < 60) begin
         len = 2 * $urandom_range(1, 3);
      end else if (r < 76) begin
         len = 2 * $urandom_range(4, 10);
      end else if (r < 83) begin
         len = 2 * $urandom_range(0, 10) + 1;
      end else if (r < 89) begin
         len = $urandom_range(DIGITS_PER_ENTRY + 1, DIGITS_PER_ENTRY + 4);
      end else if (r < 95) begin
         len    = 2 * $urandom_range(1, 4);
         bad_at = $urandom_range(0, len - 1);
      end else begin
         len = 0;
      end
      for (int i = 0; i < len; i++) begin
         digs[i] = DIGIT_W'($urandom);
         send_item(OP_LIST_CHAR, (i == bad_at) ? bad_char() : digit_char(digs[i]));
      end
      if (with_sep || len == 0) begin
         send_item(OP_LIST_CHAR, sep_char());
      end
      if (bad_at < 0 && len > 0 && len % 2 == 0 && len <= DIGITS_PER_ENTRY) begin
         pool_len[pool_next] = len;
         for (int i = 0; i < len; i++) begin
            pool_digit[pool_next][i] = digs[i];
         end
         pool_next = (pool_next + 1) % POOL_SIZE;
         if (pool_fill < POOL_SIZE) begin
            pool_fill++;
         end
      end
   endtask

   task automatic send_list();
      int n;
      if ($urandom_range(0, 99) < 70) begin
         send_item(OP_CLEAR, CHARACTER_W'($urandom));
      end
      n = $urandom_range(1, 11);
      for (int t = 0; t < n; t++) begin
         send_token(t != n - 1 || $urandom_range(0, 1) == 1);
      end
      send_item(OP_LIST_END, CHARACTER_W'($urandom));
   endtask

   task automatic send_query();
      logic [DIGIT_W-1:0] digs [32];
      int len;
      int slot;
      int r;
      int bad_at;
      bad_at = -1;
      r      = $urandom_range(0, 99);
      if (pool_fill == 0 || r >= 85) begin
         len = ($urandom_range(0, 99) < 80) ? 2 * $urandom_range(0, 4)
               : $urandom_range(DIGITS_PER_ENTRY - 1, DIGITS_PER_ENTRY + 3);
         for (int i = 0; i < len; i++) begin
            digs[i] = DIGIT_W'($urandom);
         end
      end else begin
         slot = $urandom_range(0, pool_fill - 1);
         len  = pool_len[slot];
         for (int i = 0; i < len; i++) begin
            digs[i] = pool_digit[slot][i];
         end
         if (r >= 60 && r < 70) begin
            digs[$urandom_range(0, len - 1)] ^= DIGIT_W'($urandom_range(1, 15));
         end else if (r >= 70 && r < 77) begin
            if ($urandom_range(0, 1) == 1) begin
               len--;
            end else begin
               digs[len] = DIGIT_W'($urandom);
               len++;
            end
         end else if (r >= 77) begin
            bad_at = $urandom_range(0, len - 1);
         end
      end
      for (int i = 0; i < len; i++) begin
         send_item(OP_QUERY_CHAR, (i == bad_at) ? bad_char() : digit_char(digs[i]));
      end
      send_item(OP_QUERY_END, CHARACTER_W'($urandom));
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 3);
      repeat (n) begin
         send_item(OPERATION_W'($urandom_range(OP_CLEAR, OP_SPARE_LAST)),
                   CHARACTER_W'($urandom));
      end
   endtask

   initial begin
      int r;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.operation = OP_CLEAR;
      req_chan.character = '0;
      send_idle_pct      = 0;
      rsp_stall_pct      = 0;
      hold_off_asked     = 0;
      items_sent         = 0;
      pool_fill          = 0;
      pool_next          = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_item(OP_CLEAR, 8'hFF);
      send_item(OP_LIST_CHAR, "a");
      send_item(OP_LIST_CHAR, "B");
      send_item(OP_LIST_CHAR, CH_COMMA);
      send_item(OP_LIST_CHAR, "F");
      send_item(OP_LIST_CHAR, 8'h00);
      send_item(OP_LIST_CHAR, CH_SEMI);
      send_item(OP_LIST_CHAR, "1");
      send_item(OP_LIST_CHAR, CH_TAB);
      send_item(OP_LIST_CHAR, 8'hFF);
      send_item(OP_LIST_CHAR, CH_LF);
      send_item(OP_LIST_END, 8'h00);
      send_item(OP_QUERY_CHAR, "A");
      send_item(OP_QUERY_CHAR, "b");
      send_item(OP_QUERY_END, 8'h01);
      send_item(OP_QUERY_END, 8'hFF);
      send_item(OP_QUERY_CHAR, "a");
      send_item(OP_LIST_CHAR, CH_CR);
      send_item(OP_QUERY_CHAR, "B");
      send_item(OP_QUERY_END, 8'h80);
      send_item(OP_SPARE_FIRST, 8'h55);
      send_item(OPERATION_W'(OP_SPARE_FIRST + 1), 8'hAA);
      send_item(OP_SPARE_LAST, 8'h7F);

      items_sent = 0;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 88;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 88;
            end
            default: begin
               send_idle_pct = 33;
               rsp_stall_pct = 33;
            end
         endcase
         if (phase == 0) begin
            hold_off_asked++;
            repeat (6) send_query();
            send_list();
            req_chan.valid <= 1'b0;
            while (pending_answers != 0) begin
               @(negedge clock);
            end
         end
         while (items_sent < (phase + 1) * ITEM_TARGET / 4) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
               send_list();
            end else if (r < 85) begin
               send_query();
            end else begin
               send_noise();
            end
         end
      end
      req_chan.valid <= 1'b0;

      while (pending_answers != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_answers == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/huam_pkg.sv
rtl/core/huam_if.sv
rtl/core/huam_ram.sv
rtl/core/hex_uid_allowlist_matcher.sv
bench/hex_uid_allowlist_matcher_checker.sv
bench/hex_uid_allowlist_matcher_tb.sv
